// ----- hdl/frws_pkg.sv -----
// Shared widths and constants for the frame rate window statistics block.
// No dependencies; used by frws_div and frame_rate_window_stats.
package frws_pkg;

	// Width of every rate result, of the scale register and of the input field.
	localparam int RATE_W      = 20;
	localparam int IN_W        = 20;
	localparam int ENTRIES_W   = 6;

	localparam logic [RATE_W-1:0] SCALE_RESET = 20'd1000;

endpackage

// ----- hdl/frame_rate_window_stats.sv -----
// Top level of the frame rate window statistics block: duration window as a
// chain of frws_cell, one shared frws_div, control and result registers.
// Depends on frws_pkg, frws_cell and frws_div.
//
//  channel  signals                                   direction  width
//  in       in_valid, in_ready, duration_ms           sink       20
//  out      out_valid, out_ready, current_rate,       source     20/20/20/6
//           min_rate, max_rate, window_entries
//  cfg      cfg_wr_en, cfg_wr_data (rate_scale)       sink       20
//
// The window chain rotates once through all WINDOW cells to find the extremes,
// then the single restoring divider runs three times at one bit per cycle.
// Reset clears the fill count, the control state and the output valid, and
// sets rate_scale to 1000; the stored durations are not cleared.
// A result waiting in the output register does not hold back the next input
// transfer; only a finished result that still finds the register full waits.
module frame_rate_window_stats #(
	parameter int WINDOW        = 60,
	parameter int DURATION_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [frws_pkg::IN_W-1:0]     duration_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [frws_pkg::RATE_W-1:0]   current_rate,
	output logic [frws_pkg::RATE_W-1:0]   min_rate,
	output logic [frws_pkg::RATE_W-1:0]   max_rate,
	output logic [frws_pkg::ENTRIES_W-1:0] window_entries,
	input  logic                          cfg_wr_en,
	input  logic [frws_pkg::RATE_W-1:0]   cfg_wr_data
);

	localparam int DUR_W = DURATION_BITS;
	localparam int EXT_W = (DUR_W > frws_pkg::IN_W) ? DUR_W : frws_pkg::IN_W;
	localparam int NUM_W = ((DUR_W > frws_pkg::RATE_W) ? DUR_W : frws_pkg::RATE_W) + 2;
	localparam int DEN_W = DUR_W + 1;
	localparam int CNT_W = $clog2(WINDOW + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SEL_CUR,
		SEL_MIN,
		SEL_MAX
	} sel_t;

	state_t                      state_q;
	sel_t                        sel_q;
	logic [CNT_W-1:0]            fill_q;
	logic [CNT_W-1:0]            scan_cnt_q;
	logic                        out_valid_q;
	logic [frws_pkg::RATE_W-1:0] rate_scale_q;

	logic [DUR_W-1:0]            cur_q;
	logic [DUR_W-1:0]            largest_q;
	logic [DUR_W-1:0]            smallest_q;
	logic [frws_pkg::RATE_W-1:0] rate_cur_q;
	logic [frws_pkg::RATE_W-1:0] rate_min_q;
	logic [frws_pkg::RATE_W-1:0] rate_max_q;
	logic [frws_pkg::RATE_W-1:0] current_rate_q;
	logic [frws_pkg::RATE_W-1:0] min_rate_q;
	logic [frws_pkg::RATE_W-1:0] max_rate_q;
	logic [CNT_W+frws_pkg::ENTRIES_W-1:0] entries_q;

	logic                        accept;
	logic                        rotate;
	logic                        shift;
	logic [EXT_W-1:0]            d_ext;
	logic [EXT_W-1:0]            dur_max_ext;
	logic [DUR_W-1:0]            d_sat;
	logic [DUR_W-1:0]            cell_out [WINDOW];
	logic [DUR_W-1:0]            tail;
	logic [CNT_W:0]              pos_sum;
	logic                        tail_valid;
	logic                        scan_last;
	logic                        can_emit;
	logic [DUR_W-1:0]            x_sel;
	logic [DUR_W-1:0]            x_clamped;
	logic [NUM_W-1:0]            div_num;
	logic [DEN_W-1:0]            div_den;
	logic                        div_start;
	logic                        div_done;
	logic [frws_pkg::RATE_W-1:0] div_quot;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign rotate   = (state_q == ST_SCAN);
	assign shift    = accept || rotate;

	// Saturate the duration to the stored width.
	assign d_ext       = EXT_W'(duration_ms);
	assign dur_max_ext = EXT_W'({DUR_W{1'b1}});
	assign d_sat       = (d_ext > dur_max_ext) ? {DUR_W{1'b1}} : d_ext[DUR_W-1:0];

	// New durations enter at cell 0 and the oldest falls off the end. During
	// the scan the chain is closed into a ring and makes one full turn.
	assign tail = cell_out[WINDOW-1];

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic [DUR_W-1:0] cell_in;
		if (i == 0) begin : g_head
			assign cell_in = accept ? d_sat : tail;
		end else begin : g_body
			assign cell_in = cell_out[i-1];
		end
		frws_cell #(
			.DUR_W(DUR_W)
		) u_cell (
			.clk  (clk),
			.shift(shift),
			.din  (cell_in),
			.dout (cell_out[i])
		);
	end

	// At scan step k the tail holds the entry from cell WINDOW-1-k, which is
	// filled when that index is below the fill count.
	assign pos_sum    = {1'b0, scan_cnt_q} + {1'b0, fill_q};
	assign tail_valid = (pos_sum >= (CNT_W+1)'(WINDOW));
	assign scan_last  = (scan_cnt_q == CNT_W'(WINDOW - 1));
	assign can_emit   = !out_valid_q || out_ready;

	always_comb begin
		unique case (sel_q)
			SEL_CUR: x_sel = cur_q;
			SEL_MIN: x_sel = largest_q;
			SEL_MAX: x_sel = smallest_q;
			default: x_sel = cur_q;
		endcase
	end

	// Every divisor is taken as at least one; rate = (2*scale + x) / (2*x).
	assign x_clamped = (x_sel == '0) ? DUR_W'(1) : x_sel;
	assign div_num   = (NUM_W'(rate_scale_q) << 1) + NUM_W'(x_clamped);
	assign div_den   = {x_clamped, 1'b0};
	assign div_start = (state_q == ST_DIV_START);

	frws_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sel_q        <= SEL_CUR;
			fill_q       <= '0;
			scan_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
			rate_scale_q <= frws_pkg::SCALE_RESET;
		end else begin
			if (cfg_wr_en) begin
				rate_scale_q <= cfg_wr_data;
			end
			if ((state_q == ST_DONE) && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (fill_q != CNT_W'(WINDOW)) begin
							fill_q <= fill_q + 1'b1;
						end
						scan_cnt_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_last) begin
						sel_q   <= SEL_CUR;
						state_q <= ST_DIV_START;
					end
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						unique case (sel_q)
							SEL_CUR: begin
								sel_q   <= SEL_MIN;
								state_q <= ST_DIV_START;
							end
							SEL_MIN: begin
								sel_q   <= SEL_MAX;
								state_q <= ST_DIV_START;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					if (can_emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q      <= d_sat;
			largest_q  <= '0;
			smallest_q <= {DUR_W{1'b1}};
		end else if (rotate && tail_valid) begin
			if (tail > largest_q) begin
				largest_q <= tail;
			end
			if (tail < smallest_q) begin
				smallest_q <= tail;
			end
		end
		if ((state_q == ST_DIV_WAIT) && div_done) begin
			unique case (sel_q)
				SEL_CUR: rate_cur_q <= div_quot;
				SEL_MIN: rate_min_q <= div_quot;
				default: rate_max_q <= div_quot;
			endcase
		end
		if ((state_q == ST_DONE) && can_emit) begin
			current_rate_q <= rate_cur_q;
			min_rate_q     <= rate_min_q;
			max_rate_q     <= rate_max_q;
			entries_q      <= (CNT_W+frws_pkg::ENTRIES_W)'(fill_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign current_rate   = current_rate_q;
	assign min_rate       = min_rate_q;
	assign max_rate       = max_rate_q;
	assign window_entries = entries_q[frws_pkg::ENTRIES_W-1:0];

	// The fill count never passes the window depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW))
		else $error("fill count beyond window depth");

	// An accepted item keeps the input closed in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input reopened straight after a transfer");

	// The divider only finishes while the controller waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside the wait state");

	// The current duration lies in the window, so its rate lies between the extremes.
	a_rate_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((min_rate <= current_rate) && (current_rate <= max_rate)))
		else $error("rates out of order");

endmodule

// ----- hdl/frws_cell.sv -----
// One cell of the duration window: a stored duration that moves on to the
// next cell whenever the chain shifts. No package dependencies.
module frws_cell #(
	parameter int DUR_W = 20
) (
	input  logic             clk,
	input  logic             shift,
	input  logic [DUR_W-1:0] din,
	output logic [DUR_W-1:0] dout
);

	logic [DUR_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

// ----- hdl/frws_div.sv -----
// Restoring divider giving a RATE_W-bit quotient, one bit per cycle.
// Depends on frws_pkg for RATE_W.
module frws_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [frws_pkg::RATE_W-1:0] quot
);

	localparam int CNT_W = $clog2(frws_pkg::RATE_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [DEN_W-1:0]              rem_q;
	logic [DEN_W-1:0]              den_q;
	logic [frws_pkg::RATE_W-1:0]   low_q;
	logic [frws_pkg::RATE_W-1:0]   quot_q;
	logic [NUM_W-1:0]              num_high;
	logic [DEN_W:0]                trial;
	logic                          fits;

	// The quotient is known to fit in RATE_W bits, so the upper numerator
	// bits are already below the divisor and can seed the remainder.
	assign num_high = num >> frws_pkg::RATE_W;
	assign trial    = {rem_q, low_q[frws_pkg::RATE_W-1]};
	assign fits     = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(frws_pkg::RATE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num_high[DEN_W-1:0];
			den_q  <= den;
			low_q  <= num[frws_pkg::RATE_W-1:0];
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			low_q  <= {low_q[frws_pkg::RATE_W-2:0], 1'b0};
			quot_q <= {quot_q[frws_pkg::RATE_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
